// ----- src/ipts_pkg.sv -----
`timescale 1ns / 1ps
package ipts_pkg;

  // Map size defaults
  localparam int unsigned MapWidthDef  = 512;
  localparam int unsigned MapHeightDef = 512;

  // Refinement rounds per rendered pixel
  localparam int unsigned Rounds = 5;

  // Field widths
  localparam int unsigned PixW   = 9;
  localparam int unsigned HeightW = 8;
  localparam int unsigned ColorW = 24;
  localparam int unsigned GainW  = 16;

  // Shared multiply-add unit widths
  localparam int unsigned AccW = 26;
  localparam int unsigned MulW = 17;
  localparam int unsigned ResW = 35;

  typedef enum logic [1:0] {
    CMD_LOAD_HEIGHT = 2'd0,
    CMD_LOAD_COLOR  = 2'd1,
    CMD_RENDER      = 2'd2
  } cmd_e;

  typedef enum logic {
    CFG_GAIN_X = 1'b0,
    CFG_GAIN_Y = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_START_WB,
    ST_SAMP,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_H4,
    ST_OFF_X,
    ST_OFF_Y,
    ST_OFF_WB,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [PixW-1:0]    pixel_x;
    logic [PixW-1:0]    pixel_y;
    logic [HeightW-1:0] height_value;
    logic [ColorW-1:0]  color_value;
  } in_item_t;

  typedef struct packed {
    logic [ColorW-1:0] color_out;
    logic [PixW-1:0]   out_x;
    logic [PixW-1:0]   out_y;
  } out_item_t;

  // Operands of one multiply-add: acc + m1 * m2
  typedef struct packed {
    logic signed [AccW-1:0] acc;
    logic signed [MulW-1:0] m1;
    logic signed [MulW-1:0] m2;
  } mac_op_t;

endpackage

// ----- src/ipts_store.sv -----
`timescale 1ns / 1ps
module ipts_store #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ipts_mac.sv -----
`timescale 1ns / 1ps
module ipts_mac
  import ipts_pkg::*;
(
  input  logic                   clk_i,
  input  mac_op_t                op_i,
  output logic signed [ResW-1:0] res_o
);

  logic signed [ResW-1:0] res_q;
  logic signed [ResW-1:0] res_d;

  // Lerp (a*256 + (b-a)*k) and offset (h*gain) both map onto this
  assign res_d = ResW'(op_i.acc) + ResW'(op_i.m1 * op_i.m2);

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- src/iterative_parallax_texture_sampler.sv -----
`timescale 1ns / 1ps
// Parallax texture sampler. Command 0 and 1 write one height or color pixel,
// with no result; loads outside the map and command 3 are dropped. Command 2
// renders one pixel, paced by the one read port of each map store (four corner
// reads per bilinear sample) and by the single multiply-add unit that does
// every interpolation and offset multiply in turn: a start height read, five
// refinement rounds of corner reads, height lerps and offset multiplies, the
// final color sample with a lerp per channel, and the result hand-over. The block
// is not ready while a render runs. A finished result sits in an output
// register, so loads keep flowing while it waits. Map contents are undefined
// until written; gains reset to zero and must only be written while idle.
module iterative_parallax_texture_sampler
  import ipts_pkg::*;
#(
  parameter int unsigned MAP_WIDTH  = MapWidthDef,
  parameter int unsigned MAP_HEIGHT = MapHeightDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [GainW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MAP_WIDTH * MAP_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned XW    = $clog2(MAP_WIDTH);
  localparam int unsigned YW    = $clog2(MAP_HEIGHT);
  localparam logic signed [13:0] MaxX = 14'(MAP_WIDTH - 1);
  localparam logic signed [13:0] MaxY = 14'(MAP_HEIGHT - 1);

  state_e state_q, state_d;

  logic [GainW-1:0]  gain_x_q, gain_y_q;
  logic [PixW-1:0]   px_q, py_q;
  logic [15:0]       h_q;
  logic signed [17:0] tx_q, ty_q;
  logic [2:0]        cnt_q;
  logic [2:0]        round_q;
  logic [1:0]        chan_q;
  logic [HeightW-1:0] hc_q [4];
  logic [ColorW-1:0] cc_q [4];
  logic [15:0]       i1_q;
  logic [7:0]        a_q;
  logic [ColorW-1:0] col_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              in_xfer, out_xfer;
  mac_op_t           mac_op;
  logic signed [ResW-1:0] mac_res;
  logic [HeightW-1:0] h_rd;
  logic [ColorW-1:0] c_rd;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;

  // Load address and map bounds check
  logic             in_map;
  logic             we_h, we_c;
  logic [AddrW-1:0] waddr;

  assign in_map = ({4'b0, in_data_i.pixel_x} < 13'(MAP_WIDTH)) &&
                  ({4'b0, in_data_i.pixel_y} < 13'(MAP_HEIGHT));
  assign waddr  = AddrW'(AddrW'(in_data_i.pixel_y) * AddrW'(MAP_WIDTH)) +
                  AddrW'(in_data_i.pixel_x);
  assign we_h   = in_xfer && in_map && (in_data_i.command == CMD_LOAD_HEIGHT);
  assign we_c   = in_xfer && in_map && (in_data_i.command == CMD_LOAD_COLOR);

  // Sample position: integer part floored, low byte is the fraction
  logic signed [19:0] coord_x, coord_y;
  logic signed [11:0] ip_x, ip_y;
  logic [7:0]         fx, fy;
  logic [1:0]         corner;
  logic signed [13:0] cx, cy;
  logic [XW-1:0]      cx_c;
  logic [YW-1:0]      cy_c;
  logic [AddrW-1:0]   raddr;

  assign coord_x = $signed({3'b0, px_q, 8'b0}) + $signed({{2{tx_q[17]}}, tx_q});
  assign coord_y = $signed({3'b0, py_q, 8'b0}) + $signed({{2{ty_q[17]}}, ty_q});
  assign ip_x    = coord_x[19:8];
  assign ip_y    = coord_y[19:8];
  assign fx      = coord_x[7:0];
  assign fy      = coord_y[7:0];
  assign corner  = cnt_q[1:0];
  assign cx      = $signed({{2{ip_x[11]}}, ip_x}) + $signed({13'b0, corner[0]});
  assign cy      = $signed({{2{ip_y[11]}}, ip_y}) + $signed({13'b0, corner[1]});

  // Clamp to the map edge
  always_comb begin
    if (cx[13]) begin
      cx_c = '0;
    end else if (cx > MaxX) begin
      cx_c = XW'(MaxX);
    end else begin
      cx_c = XW'(cx);
    end
    if (cy[13]) begin
      cy_c = '0;
    end else if (cy > MaxY) begin
      cy_c = YW'(MaxY);
    end else begin
      cy_c = YW'(cy);
    end
  end

  assign raddr = AddrW'(AddrW'(cy_c) * AddrW'(MAP_WIDTH)) + AddrW'(cx_c);

  ipts_store #(
    .DATA_W (HeightW),
    .DEPTH  (Depth)
  ) u_height (
    .clk_i   (clk_i),
    .we_i    (we_h),
    .waddr_i (waddr),
    .wdata_i (in_data_i.height_value),
    .raddr_i (raddr),
    .rdata_o (h_rd)
  );

  ipts_store #(
    .DATA_W (ColorW),
    .DEPTH  (Depth)
  ) u_color (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (waddr),
    .wdata_i (in_data_i.color_value),
    .raddr_i (raddr),
    .rdata_o (c_rd)
  );

  ipts_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .res_o (mac_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_data_i.command == CMD_RENDER)) begin
          state_d = ST_START;
        end
      end
      ST_START:    state_d = ST_START_WB;
      ST_START_WB: state_d = ST_SAMP;
      ST_SAMP: begin
        if (cnt_q == 3'd4) begin
          state_d = (round_q == 3'(Rounds)) ? ST_C1 : ST_H1;
        end
      end
      ST_H1:     state_d = ST_H2;
      ST_H2:     state_d = ST_H3;
      ST_H3:     state_d = ST_H4;
      ST_H4:     state_d = ST_OFF_X;
      ST_OFF_X:  state_d = ST_OFF_Y;
      ST_OFF_Y:  state_d = ST_OFF_WB;
      ST_OFF_WB: state_d = ST_SAMP;
      ST_C1:     state_d = ST_C2;
      ST_C2:     state_d = ST_C3;
      ST_C3:     state_d = ST_C4;
      ST_C4:     state_d = (chan_q == 2'd2) ? ST_DONE : ST_C1;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Operands for the shared unit
  always_comb begin
    mac_op = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_H1: begin
        mac_op.acc = $signed({10'b0, hc_q[0], 8'b0});
        mac_op.m1  = $signed({9'b0, hc_q[1]}) - $signed({9'b0, hc_q[0]});
        mac_op.m2  = $signed({9'b0, fx});
      end
      ST_H2: begin
        mac_op.acc = $signed({10'b0, hc_q[2], 8'b0});
        mac_op.m1  = $signed({9'b0, hc_q[3]}) - $signed({9'b0, hc_q[2]});
        mac_op.m2  = $signed({9'b0, fx});
      end
      ST_H3: begin
        mac_op.acc = $signed({2'b0, i1_q, 8'b0});
        mac_op.m1  = $signed({1'b0, mac_res[15:0]}) - $signed({1'b0, i1_q});
        mac_op.m2  = $signed({9'b0, fy});
      end
      ST_OFF_X: begin
        mac_op.m1 = $signed({1'b0, h_q});
        mac_op.m2 = $signed({gain_x_q[15], gain_x_q});
      end
      ST_OFF_Y: begin
        mac_op.m1 = $signed({1'b0, h_q});
        mac_op.m2 = $signed({gain_y_q[15], gain_y_q});
      end
      ST_C1: begin
        mac_op.acc = $signed({10'b0, cc_q[0][chan_q*8 +: 8], 8'b0});
        mac_op.m1  = $signed({9'b0, cc_q[1][chan_q*8 +: 8]}) -
                     $signed({9'b0, cc_q[0][chan_q*8 +: 8]});
        mac_op.m2  = $signed({9'b0, fx});
      end
      ST_C2: begin
        mac_op.acc = $signed({10'b0, cc_q[2][chan_q*8 +: 8], 8'b0});
        mac_op.m1  = $signed({9'b0, cc_q[3][chan_q*8 +: 8]}) -
                     $signed({9'b0, cc_q[2][chan_q*8 +: 8]});
        mac_op.m2  = $signed({9'b0, fx});
      end
      ST_C3: begin
        mac_op.acc = $signed({10'b0, a_q, 8'b0});
        mac_op.m1  = $signed({9'b0, mac_res[15:8]}) - $signed({9'b0, a_q});
        mac_op.m2  = $signed({9'b0, fy});
      end
      default: mac_op = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_x_q    <= '0;
      gain_y_q    <= '0;
      cnt_q       <= '0;
      round_q     <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_GAIN_X) begin
          gain_x_q <= cfg_data_i;
        end else begin
          gain_y_q <= cfg_data_i;
        end
      end
      case (state_q)
        ST_IDLE: begin
          cnt_q   <= '0;
          round_q <= '0;
          chan_q  <= '0;
        end
        ST_SAMP:   cnt_q   <= (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
        ST_OFF_WB: round_q <= round_q + 3'd1;
        ST_C4:     chan_q  <= (chan_q == 2'd2) ? 2'd0 : chan_q + 2'd1;
        default: ;
      endcase
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          px_q <= in_data_i.pixel_x;
          py_q <= in_data_i.pixel_y;
          tx_q <= '0;
          ty_q <= '0;
        end
      end
      ST_START_WB: h_q <= {h_rd, 8'b0};
      ST_SAMP: begin
        if (cnt_q != 3'd0) begin
          hc_q[2'(cnt_q - 3'd1)] <= h_rd;
          cc_q[2'(cnt_q - 3'd1)] <= c_rd;
        end
      end
      ST_H2: i1_q <= mac_res[15:0];
      ST_H4: h_q <= 16'(({1'b0, h_q} + {1'b0, mac_res[23:8]}) >> 1);
      ST_OFF_Y: tx_q <= mac_res[32:15];
      ST_OFF_WB: ty_q <= mac_res[32:15];
      ST_C2: a_q <= mac_res[15:8];
      ST_C4: col_q[chan_q*8 +: 8] <= mac_res[15:8];
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.color_out <= col_q;
          out_q.out_x     <= px_q;
          out_q.out_y     <= py_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
